// ----- design/cau_pkg.sv -----
// Package for the complex arithmetic unit: widths, opcodes, the division
// stage record and the rounding and saturation helpers. It depends on nothing.
`default_nettype none

package cau_pkg;

    localparam int DW = 32;            // width of each operand and result part
    localparam int FB = 16;            // fraction bits
    localparam int PW = 2 * DW;        // width of one exact product
    localparam int SW = 2 * DW + 1;    // width of a sum of two products
    localparam int MW = 2 * DW;        // magnitude of such a sum
    localparam int NW = MW + FB;       // dividend after the fraction shift
    localparam int QB = DW;            // quotient bits worked out
    localparam int RW = 2 * DW;        // remainder and divisor width

    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] RES_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] RES_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [QB-1:0] Q_HALF  = {1'b1, {(QB-1){1'b0}}};

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_EQ  = 3'd4,
        CMD_NE  = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [DW-1:0] res;
        logic          ov;
    } t_sat;

    // One stage of the quotient pipeline, both parts side by side.
    typedef struct packed {
        logic          vld;
        logic          is_div;
        logic          dz;
        logic [DW-1:0] res_re;
        logic [DW-1:0] res_im;
        logic          cmp;
        logic          ov;
        logic [RW-1:0] d;
        logic [RW-1:0] rem_re;
        logic [RW-1:0] rem_im;
        logic [QB-1:0] low_re;
        logic [QB-1:0] low_im;
        logic [QB-1:0] q_re;
        logic [QB-1:0] q_im;
        logic          neg_re;
        logic          neg_im;
        logic          pov_re;
        logic          pov_im;
    } t_dstg;

    function automatic t_sat sat(input logic signed [SW-1:0] v);
        t_sat s;
        if (v > SAT_MAX) begin
            s.res = RES_MAX;
            s.ov  = 1'b1;
        end else if (v < SAT_MIN) begin
            s.res = RES_MIN;
            s.ov  = 1'b1;
        end else begin
            s.res = v[DW-1:0];
            s.ov  = 1'b0;
        end
        return s;
    endfunction

    // Shift right by the fraction bits, rounding toward zero.
    function automatic logic signed [SW-1:0] trunc_shift(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] adj;
        adj = v + $signed({{(SW-FB){1'b0}}, {FB{v[SW-1]}}});
        return adj >>> FB;
    endfunction

    // One restoring step: returns {quotient bit, new remainder}.
    function automatic logic [RW:0] rem_step(input logic [RW-1:0] rem,
                                             input logic nbit,
                                             input logic [RW-1:0] d);
        logic [RW:0] sh;
        sh = {rem, nbit};
        if (sh >= {1'b0, d}) begin
            sh = sh - {1'b0, d};
            return {1'b1, sh[RW-1:0]};
        end
        return {1'b0, sh[RW-1:0]};
    endfunction

    // Sign and saturation of a finished quotient.
    function automatic t_sat div_fin(input logic [QB-1:0] q, input logic neg,
                                     input logic pov);
        t_sat s;
        if (!neg) begin
            s.ov  = pov || q[QB-1];
            s.res = s.ov ? RES_MAX : q[DW-1:0];
        end else begin
            s.ov  = pov || (q > Q_HALF);
            s.res = s.ov ? RES_MIN : DW'(-q);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- design/complex_arithmetic_unit.sv -----
// Complex arithmetic unit top level: a fully pipelined complex add, subtract,
// multiply, divide and compare on Q16.16 parts. Depends on cau_pkg.
`default_nettype none

// The unit takes one item per clock cycle unless the output stalls, and returns
// one result item for each, in order. The divider works out one quotient bit
// per pipeline stage over 32 stages, after three stages of products, sums and
// divider setup and before one output register. Every operation travels the
// same path, so results never reorder. When the output item is not taken the
// whole pipeline holds, and o_ready falls at once.
// Multiply and divide results are truncated toward zero; a part that leaves the
// Q16.16 range saturates and raises o_overflow. A divide whose divisor has zero
// squared magnitude returns zero with o_divide_by_zero set.
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [2:0]           i_cmd,
    input  wire logic signed [DW-1:0] i_a_re,
    input  wire logic signed [DW-1:0] i_a_im,
    input  wire logic signed [DW-1:0] i_b_re,
    input  wire logic signed [DW-1:0] i_b_im,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [DW-1:0]      o_res_re,
    output logic signed [DW-1:0]      o_res_im,
    output logic                      o_compare_true,
    output logic                      o_divide_by_zero,
    output logic                      o_overflow
);

    // The whole pipeline moves together whenever the output register can take.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Stage 1: the six exact products, the add or subtract, the compare.
    logic                 r1_vld;
    logic [2:0]           r1_cmd;
    logic signed [PW-1:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_bb, r1_p_cc;
    logic signed [DW:0]   r1_s_re, r1_s_im;
    logic                 r1_same;

    logic signed [DW:0] n1_s_re, n1_s_im;

    always_comb begin
        if (i_cmd == CMD_SUB) begin
            n1_s_re = $signed({i_a_re[DW-1], i_a_re}) - $signed({i_b_re[DW-1], i_b_re});
            n1_s_im = $signed({i_a_im[DW-1], i_a_im}) - $signed({i_b_im[DW-1], i_b_im});
        end else begin
            n1_s_re = $signed({i_a_re[DW-1], i_a_re}) + $signed({i_b_re[DW-1], i_b_re});
            n1_s_im = $signed({i_a_im[DW-1], i_a_im}) + $signed({i_b_im[DW-1], i_b_im});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld  <= i_valid;
            r1_cmd  <= i_cmd;
            r1_p_rr <= i_a_re * i_b_re;
            r1_p_ii <= i_a_im * i_b_im;
            r1_p_ri <= i_a_re * i_b_im;
            r1_p_ir <= i_a_im * i_b_re;
            r1_p_bb <= i_b_re * i_b_re;
            r1_p_cc <= i_b_im * i_b_im;
            r1_s_re <= n1_s_re;
            r1_s_im <= n1_s_im;
            r1_same <= (i_a_re == i_b_re) && (i_a_im == i_b_im);
        end
    end

    // Stage 2: sums of products, the divisor, and the finished simple results.
    logic                 r2_vld;
    logic [2:0]           r2_cmd;
    logic signed [SW-1:0] r2_mul_re, r2_mul_im, r2_div_re, r2_div_im;
    logic [RW-1:0]        r2_d;
    logic [DW-1:0]        r2_res_re, r2_res_im;
    logic                 r2_cmp, r2_ov;

    logic signed [SW-1:0] x_rr, x_ii, x_ri, x_ir;
    t_sat                 sa_re, sa_im;
    logic [DW-1:0]        n2_res_re, n2_res_im;
    logic                 n2_cmp, n2_ov;

    always_comb begin
        x_rr  = $signed({r1_p_rr[PW-1], r1_p_rr});
        x_ii  = $signed({r1_p_ii[PW-1], r1_p_ii});
        x_ri  = $signed({r1_p_ri[PW-1], r1_p_ri});
        x_ir  = $signed({r1_p_ir[PW-1], r1_p_ir});
        sa_re = sat($signed({{(SW-DW-1){r1_s_re[DW]}}, r1_s_re}));
        sa_im = sat($signed({{(SW-DW-1){r1_s_im[DW]}}, r1_s_im}));
        n2_res_re = '0;
        n2_res_im = '0;
        n2_cmp    = 1'b0;
        n2_ov     = 1'b0;
        case (r1_cmd)
            CMD_ADD, CMD_SUB: begin
                n2_res_re = sa_re.res;
                n2_res_im = sa_im.res;
                n2_ov     = sa_re.ov || sa_im.ov;
            end
            CMD_EQ:  n2_cmp = r1_same;
            CMD_NE:  n2_cmp = !r1_same;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld    <= r1_vld;
            r2_cmd    <= r1_cmd;
            r2_mul_re <= x_rr - x_ii;
            r2_mul_im <= x_ri + x_ir;
            r2_div_re <= x_rr + x_ii;
            r2_div_im <= x_ir - x_ri;
            r2_d      <= r1_p_bb + r1_p_cc;
            r2_res_re <= n2_res_re;
            r2_res_im <= n2_res_im;
            r2_cmp    <= n2_cmp;
            r2_ov     <= n2_ov;
        end
    end

    // Stage 3 (divider stage 0): multiply results, dividend magnitudes and the
    // check that the quotient would not fit in the bits worked out.
    t_dstg               r_dv [0:QB];
    t_dstg               n_dv [0:QB];
    logic [MW-1:0]       mag_re, mag_im;
    logic [NW-1:0]       num_re, num_im;
    logic signed [SW-1:0] neg_tmp_re, neg_tmp_im;
    t_sat                sm_re, sm_im;
    logic [RW:0]         st_re [1:QB];
    logic [RW:0]         st_im [1:QB];

    always_comb begin
        neg_tmp_re = -r2_div_re;
        neg_tmp_im = -r2_div_im;
        mag_re = r2_div_re[SW-1] ? neg_tmp_re[MW-1:0] : r2_div_re[MW-1:0];
        mag_im = r2_div_im[SW-1] ? neg_tmp_im[MW-1:0] : r2_div_im[MW-1:0];
        num_re = {mag_re, {FB{1'b0}}};
        num_im = {mag_im, {FB{1'b0}}};
        sm_re  = sat(trunc_shift(r2_mul_re));
        sm_im  = sat(trunc_shift(r2_mul_im));

        n_dv[0].vld    = r2_vld;
        n_dv[0].is_div = (r2_cmd == CMD_DIV);
        n_dv[0].dz     = (r2_d == '0);
        n_dv[0].d      = r2_d;
        n_dv[0].cmp    = r2_cmp;
        if (r2_cmd == CMD_MUL) begin
            n_dv[0].res_re = sm_re.res;
            n_dv[0].res_im = sm_im.res;
            n_dv[0].ov     = sm_re.ov || sm_im.ov;
        end else begin
            n_dv[0].res_re = r2_res_re;
            n_dv[0].res_im = r2_res_im;
            n_dv[0].ov     = r2_ov;
        end
        n_dv[0].rem_re = RW'(num_re[NW-1:QB]);
        n_dv[0].rem_im = RW'(num_im[NW-1:QB]);
        n_dv[0].low_re = num_re[QB-1:0];
        n_dv[0].low_im = num_im[QB-1:0];
        n_dv[0].q_re   = '0;
        n_dv[0].q_im   = '0;
        n_dv[0].neg_re = r2_div_re[SW-1];
        n_dv[0].neg_im = r2_div_im[SW-1];
        n_dv[0].pov_re = RW'(num_re[NW-1:QB]) >= r2_d;
        n_dv[0].pov_im = RW'(num_im[NW-1:QB]) >= r2_d;

        // Divider stages 1..QB: one quotient bit for each part per stage.
        for (int k = 1; k <= QB; k++) begin
            st_re[k] = rem_step(r_dv[k-1].rem_re, r_dv[k-1].low_re[QB-1], r_dv[k-1].d);
            st_im[k] = rem_step(r_dv[k-1].rem_im, r_dv[k-1].low_im[QB-1], r_dv[k-1].d);
            n_dv[k]        = r_dv[k-1];
            n_dv[k].rem_re = st_re[k][RW-1:0];
            n_dv[k].rem_im = st_im[k][RW-1:0];
            n_dv[k].low_re = {r_dv[k-1].low_re[QB-2:0], 1'b0};
            n_dv[k].low_im = {r_dv[k-1].low_im[QB-2:0], 1'b0};
            n_dv[k].q_re   = {r_dv[k-1].q_re[QB-2:0], st_re[k][RW]};
            n_dv[k].q_im   = {r_dv[k-1].q_im[QB-2:0], st_im[k][RW]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= QB; k++) begin
            if (!i_rst_n) begin
                r_dv[k].vld <= 1'b0;
            end else if (en) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // Output register: divides get their sign and saturation here.
    t_sat fd_re, fd_im;

    always_comb begin
        fd_re = div_fin(r_dv[QB].q_re, r_dv[QB].neg_re, r_dv[QB].pov_re);
        fd_im = div_fin(r_dv[QB].q_im, r_dv[QB].neg_im, r_dv[QB].pov_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid        <= r_dv[QB].vld;
            o_compare_true <= r_dv[QB].cmp;
            if (!r_dv[QB].is_div) begin
                o_res_re         <= r_dv[QB].res_re;
                o_res_im         <= r_dv[QB].res_im;
                o_divide_by_zero <= 1'b0;
                o_overflow       <= r_dv[QB].ov;
            end else if (r_dv[QB].dz) begin
                o_res_re         <= '0;
                o_res_im         <= '0;
                o_divide_by_zero <= 1'b1;
                o_overflow       <= 1'b0;
            end else begin
                o_res_re         <= fd_re.res;
                o_res_im         <= fd_im.res;
                o_divide_by_zero <= 1'b0;
                o_overflow       <= fd_re.ov || fd_im.ov;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A zero divisor gives a clean zero result with no other flag.
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |->
        (o_res_re == '0 && o_res_im == '0 && !o_overflow && !o_compare_true))
        else $error("divide-by-zero result is not clean");

    // A true compare carries no arithmetic result.
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_compare_true) |->
        (o_res_re == '0 && o_res_im == '0 && !o_overflow && !o_divide_by_zero))
        else $error("compare result carries arithmetic data");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !r1_vld && !r2_vld))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ----- tb/complex_arithmetic_unit_tb.sv -----
// Testbench for the complex arithmetic unit: a directed table followed by random
// items, each checked against a wide-arithmetic predictor or a typed-in value.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`default_nettype none

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 36;
    localparam int MAX_CYCLE = 400000;
    localparam int N_RANDOM  = 1130;

    // One expected result item.
    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          cmp;
        logic          dz;
        logic          ov;
    } t_res;

    // One row of the directed table; chk says whether exp was typed in.
    typedef struct {
        logic [2:0]    cmd;
        logic [DW-1:0] ar, ai, br, bi;
        bit            chk;
        t_res          exp;
    } t_row;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [2:0]    in_cmd;
    logic [DW-1:0] in_ar, in_ai, in_br, in_bi;
    logic          out_valid;
    logic          out_ready;
    logic [DW-1:0] out_re, out_im;
    logic          out_cmp, out_dz, out_ov;

    t_res   expected_results[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     recv_hold;

    complex_arithmetic_unit uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_cmd            (in_cmd),
        .i_a_re           (in_ar),
        .i_a_im           (in_ai),
        .i_b_re           (in_br),
        .i_b_im           (in_bi),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_res_re         (out_re),
        .o_res_im         (out_im),
        .o_compare_true   (out_cmp),
        .o_divide_by_zero (out_dz),
        .o_overflow       (out_ov)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamps an exact value to the Q16.16 range and flags saturation.
    function automatic logic [DW-1:0] clamp_part(input logic signed [159:0] v,
                                                 inout logic ov);
        if (v > 160'sd2147483647) begin
            ov = 1'b1;
            return RES_MAX;
        end
        if (v < -160'sd2147483648) begin
            ov = 1'b1;
            return RES_MIN;
        end
        return v[DW-1:0];
    endfunction

    // Exact quotient truncated toward zero, on signed values.
    function automatic logic signed [159:0] div_toward_zero(input logic signed [159:0] n,
                                                            input logic signed [159:0] d);
        logic [159:0] q;
        q = (n < 0 ? -n : n) / d;
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    // Works out the result the unit must give for one operand item.
    function automatic t_res complex_result(input logic [2:0] cmd,
                                            input logic signed [DW-1:0] ar,
                                            input logic signed [DW-1:0] ai,
                                            input logic signed [DW-1:0] br,
                                            input logic signed [DW-1:0] bi);
        t_res r;
        logic signed [159:0] xr, xi, yr, yi, re, im, den;
        logic same;
        r = '0;
        xr = ar; xi = ai; yr = br; yi = bi;
        same = (ar == br) && (ai == bi);
        case (cmd)
            CMD_ADD, CMD_SUB: begin
                re = (cmd == CMD_ADD) ? xr + yr : xr - yr;
                im = (cmd == CMD_ADD) ? xi + yi : xi - yi;
                r.re = clamp_part(re, r.ov);
                r.im = clamp_part(im, r.ov);
            end
            CMD_MUL: begin
                re = div_toward_zero(xr * yr - xi * yi, 160'sd65536);
                im = div_toward_zero(xr * yi + xi * yr, 160'sd65536);
                r.re = clamp_part(re, r.ov);
                r.im = clamp_part(im, r.ov);
            end
            CMD_DIV: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    re = div_toward_zero((xr * yr + xi * yi) <<< FB, den);
                    im = div_toward_zero((xi * yr - xr * yi) <<< FB, den);
                    r.re = clamp_part(re, r.ov);
                    r.im = clamp_part(im, r.ov);
                end
            end
            CMD_EQ: r.cmp = same;
            CMD_NE: r.cmp = !same;
            default: ;
        endcase
        return r;
    endfunction

    // Operand values that hit edges more often than plain random ones.
    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return RES_MAX;
            1: return RES_MIN;
            2: return '0;
            3: return 32'h0001_0000;
            4: return $urandom_range(0, 3) - 2;
            5, 6: return DW'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return $urandom;
        endcase
    endfunction

    // Offers one item, with random idle cycles before it, until it is accepted.
    // Valid stays high afterwards; the caller drops it when no item follows.
    task automatic send_item(input logic [2:0] cmd, input logic [DW-1:0] ar,
                             input logic [DW-1:0] ai, input logic [DW-1:0] br,
                             input logic [DW-1:0] bi);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_ar    <= ar;
        in_ai    <= ai;
        in_br    <= br;
        in_bi    <= bi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.push_back(complex_result(cmd, ar, ai, br, bi));
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off when recv_hold is set.
    initial begin
        int hold;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (recv_hold) begin
                out_ready <= 1'b0;
                for (hold = 0; hold < 3 * LATENCY; hold++) @(negedge clk);
                recv_hold = 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        t_res got, exp;
        if (rst_n && out_valid && out_ready) begin
            got = {out_re, out_im, out_cmp, out_dz, out_ov};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item re=%h im=%h", out_re, out_im);
            end else begin
                exp = expected_results.pop_front();
                if (got !== exp) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp re=%h im=%h c=%b dz=%b ov=%b, got re=%h im=%h c=%b dz=%b ov=%b",
                                 exp.re, exp.im, exp.cmp, exp.dz, exp.ov,
                                 got.re, got.im, got.cmp, got.dz, got.ov);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE) begin
            $display("complex_arithmetic_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        int k, phase;
        logic [2:0] cmd;
        logic [DW-1:0] ar, ai, br, bi;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_cmd = '0;
        in_ar = '0; in_ai = '0; in_br = '0; in_bi = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. Rows with chk set carry results read off directly.
        rows.push_back('{CMD_ADD, RES_MAX, RES_MIN, 32'd1, 32'hFFFF_FFFF, 1'b1,
                         '{RES_MAX, RES_MIN, 1'b0, 1'b0, 1'b1}});
        rows.push_back('{CMD_SUB, RES_MIN, RES_MAX, 32'd1, 32'hFFFF_FFFF, 1'b1,
                         '{RES_MIN, RES_MAX, 1'b0, 1'b0, 1'b1}});
        rows.push_back('{CMD_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                         32'hFFFF_0000, 1'b1,
                         '{32'h0004_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{CMD_MUL, 32'h0001_0000, 32'h0000_0000, 32'h1234_5678,
                         32'h8765_4321, 1'b1,
                         '{32'h1234_5678, 32'h8765_4321, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{CMD_MUL, RES_MIN, RES_MIN, RES_MIN, RES_MIN, 1'b0, '0});
        rows.push_back('{CMD_MUL, RES_MAX, RES_MIN, RES_MIN, RES_MAX, 1'b0, '0});
        rows.push_back('{CMD_MUL, 32'hFFFF_FFFF, 0, 32'd1, 0, 1'b0, '0});
        rows.push_back('{CMD_DIV, 32'h0001_0000, 32'h0001_0000, 0, 0, 1'b1,
                         '{0, 0, 1'b0, 1'b1, 1'b0}});
        rows.push_back('{CMD_DIV, RES_MAX, RES_MIN, 0, 0, 1'b1,
                         '{0, 0, 1'b0, 1'b1, 1'b0}});
        rows.push_back('{CMD_DIV, RES_MAX, RES_MAX, 32'd1, 0, 1'b0, '0});
        rows.push_back('{CMD_DIV, RES_MIN, RES_MIN, RES_MIN, RES_MIN, 1'b0, '0});
        rows.push_back('{CMD_DIV, 32'h0001_0000, 0, 32'h0003_0000, 32'h0004_0000,
                         1'b0, '0});
        rows.push_back('{CMD_DIV, 32'hFFFF_FFFF, 32'd1, RES_MAX, RES_MAX, 1'b0, '0});
        rows.push_back('{CMD_EQ, 32'h1234_5678, RES_MIN, 32'h1234_5678, RES_MIN, 1'b1,
                         '{0, 0, 1'b1, 1'b0, 1'b0}});
        rows.push_back('{CMD_EQ, 32'h1234_5678, RES_MIN, 32'h1234_5678, RES_MAX, 1'b1,
                         '{0, 0, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{CMD_NE, RES_MAX, 0, RES_MAX, 0, 1'b1,
                         '{0, 0, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{CMD_NE, RES_MAX, 0, RES_MIN, 0, 1'b1,
                         '{0, 0, 1'b1, 1'b0, 1'b0}});
        // Unused opcodes give an all-zero result.
        rows.push_back('{3'd6, RES_MAX, RES_MAX, RES_MAX, RES_MAX, 1'b1, '0});
        rows.push_back('{3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1'b1, '0});

        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.cmd, row.ar, row.ai, row.br, row.bi);
            // The typed-in value replaces the predictor's for checked rows.
            if (row.chk) begin
                void'(expected_results.pop_back());
                expected_results.push_back(row.exp);
            end
        end

        // Random items in three idling phases; a long receiver hold-off
        // fills the pipeline in each, and the sender drains in between.
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 37 : 0;
            for (k = 0; k < N_RANDOM / 3; k++) begin
                if (k == 40) recv_hold = 1'b1;
                cmd = 3'($urandom_range(0, 7));
                ar = pick_operand();
                ai = pick_operand();
                if (cmd >= CMD_EQ && $urandom_range(0, 1)) begin
                    br = ar;
                    bi = $urandom_range(0, 1) ? ai : pick_operand();
                end else begin
                    br = pick_operand();
                    bi = pick_operand();
                end
                send_item(cmd, ar, ai, br, bi);
            end
            in_valid <= 1'b0;
            while (expected_results.size() != 0) @(negedge clk);
        end

        repeat (LATENCY + 4) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("complex_arithmetic_unit_tb: PASS");
        else
            $display("complex_arithmetic_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
